// ----- rtl/smtks_pkg.sv -----
// Shared types and constants for the smallest-magnitude top-k selector.
`timescale 1ns / 1ps
`default_nettype none
package smtks_pkg;

	localparam int ENERGY_W = 32;
	localparam int VALUE_W  = 33;
	localparam int MAG_W    = 32;
	localparam int RANK_W   = 4;
	localparam int CFG_W    = 5;
	localparam logic [CFG_W-1:0] ROOTS_RESET = 5'd16;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_FLUSH,
		ST_DUMP
	} smtks_state_t;

	typedef struct packed {
		logic              load;
		logic              dump_step;
		logic              dump_last;
		logic [RANK_W-1:0] rank;
	} smtks_cmd_t;

	typedef struct packed {
		logic out_free;
	} smtks_status_t;

endpackage
`default_nettype wire

// ----- rtl/smtks_ctrl.sv -----
// Controller state machine: candidate intake, pipeline flush and list dump sequencing.
`timescale 1ns / 1ps
`default_nettype none
module smtks_ctrl #(
	parameter int CNT_W = 5
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_last,
	output logic                       in_ready,
	input  wire logic [CNT_W-1:0]      eff_cnt,
	input  wire smtks_pkg::smtks_status_t status,
	output smtks_pkg::smtks_cmd_t      cmd
);
	import smtks_pkg::*;

	smtks_state_t state_q;
	smtks_state_t state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             at_last;

	assign at_last = (cnt_q == (eff_cnt - CNT_W'(1)));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (in_valid && in_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_DUMP;
			end
			ST_DUMP: begin
				if (status.out_free && at_last) begin
					state_d = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.dump_step = 1'b0;
		cmd.dump_last = 1'b0;
		cmd.rank      = RANK_W'(cnt_q);
		unique case (state_q)
			ST_RUN: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_FLUSH: begin
			end
			ST_DUMP: begin
				cmd.dump_step = status.out_free;
				cmd.dump_last = at_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FLUSH) begin
				cnt_q <= '0;
			end else if (cmd.dump_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/smtks_datapath.sv -----
// Datapath: excitation stage, sorted slot list with compare-and-shift, output register.
`timescale 1ns / 1ps
`default_nettype none
module smtks_datapath #(
	parameter int MAX_ROOTS = 16,
	parameter int OCC_BITS  = 8,
	parameter int VIR_BITS  = 10,
	parameter int CNT_W     = 5
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	input  wire logic [smtks_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic [smtks_pkg::ENERGY_W-1:0]    occ_energy,
	input  wire logic [smtks_pkg::ENERGY_W-1:0]    vir_energy,
	input  wire logic [OCC_BITS-1:0]               occ_index,
	input  wire logic [VIR_BITS-1:0]               vir_index,
	input  wire smtks_pkg::smtks_cmd_t             cmd,
	output smtks_pkg::smtks_status_t               status,
	output logic [CNT_W-1:0]                       eff_cnt,
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output logic [smtks_pkg::RANK_W-1:0]           rank,
	output logic [smtks_pkg::VALUE_W-1:0]          excitation,
	output logic [OCC_BITS-1:0]                    out_occ_index,
	output logic [VIR_BITS-1:0]                    out_vir_index,
	output logic                                   entry_valid,
	output logic                                   last
);
	import smtks_pkg::*;

	logic [CFG_W-1:0] roots_q;
	logic [31:0]      roots_ext;
	logic [31:0]      eff_ext;

	logic                        valid_s1;
	logic signed [VALUE_W-1:0]   value_s1;
	logic [MAG_W-1:0]            mag_s1;
	logic [OCC_BITS-1:0]         occ_s1;
	logic [VIR_BITS-1:0]         vir_s1;
	logic signed [VALUE_W-1:0]   diff;
	logic [VALUE_W-1:0]          diff_abs;

	logic [VALUE_W-1:0]  value_q [MAX_ROOTS];
	logic [MAG_W-1:0]    mag_q   [MAX_ROOTS];
	logic [OCC_BITS-1:0] occ_q   [MAX_ROOTS];
	logic [VIR_BITS-1:0] vir_q   [MAX_ROOTS];
	logic [MAX_ROOTS-1:0] full_q;

	logic [MAX_ROOTS-1:0] active;
	logic [MAX_ROOTS-1:0] hit;
	logic [MAX_ROOTS-1:0] prior_hit;
	logic [MAX_ROOTS-1:0] first;
	logic                 out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roots_q <= ROOTS_RESET;
		end else if (cfg_valid) begin
			roots_q <= cfg_data;
		end
	end

	assign roots_ext = {{(32-CFG_W){1'b0}}, roots_q};

	always_comb begin
		priority if (roots_q == '0) begin
			eff_cnt = CNT_W'(1);
		end else if (roots_ext > 32'(MAX_ROOTS)) begin
			eff_cnt = CNT_W'(MAX_ROOTS);
		end else begin
			eff_cnt = CNT_W'(roots_ext);
		end
	end

	assign eff_ext = 32'(eff_cnt);

	assign diff     = $signed({vir_energy[ENERGY_W-1], vir_energy})
	                - $signed({occ_energy[ENERGY_W-1], occ_energy});
	assign diff_abs = diff[VALUE_W-1] ? (-diff) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.load;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_s1 <= diff;
			mag_s1   <= diff_abs[MAG_W-1:0];
			occ_s1   <= occ_index;
			vir_s1   <= vir_index;
		end
	end

	always_comb begin
		for (int k = 0; k < MAX_ROOTS; k++) begin
			active[k] = (32'(k) < eff_ext);
			hit[k]    = active[k] && (!full_q[k] || (mag_s1 < mag_q[k]));
		end
		prior_hit[0] = 1'b0;
		for (int k = 1; k < MAX_ROOTS; k++) begin
			prior_hit[k] = prior_hit[k-1] | hit[k-1];
		end
		first = hit & ~prior_hit;
	end

	for (genvar k = 0; k < MAX_ROOTS; k++) begin : g_slot
		logic [VALUE_W-1:0]  prev_value;
		logic [MAG_W-1:0]    prev_mag;
		logic [OCC_BITS-1:0] prev_occ;
		logic [VIR_BITS-1:0] prev_vir;
		logic                prev_full;
		logic [VALUE_W-1:0]  next_value;
		logic [MAG_W-1:0]    next_mag;
		logic [OCC_BITS-1:0] next_occ;
		logic [VIR_BITS-1:0] next_vir;
		logic                next_full;
		logic                next_active;

		if (k == 0) begin : g_head
			assign prev_value = '0;
			assign prev_mag   = '0;
			assign prev_occ   = '0;
			assign prev_vir   = '0;
			assign prev_full  = 1'b0;
		end else begin : g_body
			assign prev_value = value_q[k-1];
			assign prev_mag   = mag_q[k-1];
			assign prev_occ   = occ_q[k-1];
			assign prev_vir   = vir_q[k-1];
			assign prev_full  = full_q[k-1];
		end

		if (k == MAX_ROOTS - 1) begin : g_tail
			assign next_value  = '0;
			assign next_mag    = '0;
			assign next_occ    = '0;
			assign next_vir    = '0;
			assign next_full   = 1'b0;
			assign next_active = 1'b0;
		end else begin : g_inner
			assign next_value  = value_q[k+1];
			assign next_mag    = mag_q[k+1];
			assign next_occ    = occ_q[k+1];
			assign next_vir    = vir_q[k+1];
			assign next_full   = full_q[k+1];
			assign next_active = active[k+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				full_q[k] <= 1'b0;
			end else if (valid_s1 && active[k]) begin
				if (first[k]) begin
					full_q[k] <= 1'b1;
				end else if (prior_hit[k]) begin
					full_q[k] <= prev_full;
				end
			end else if (cmd.dump_step && active[k]) begin
				full_q[k] <= next_active ? next_full : 1'b0;
			end
		end

		always_ff @(posedge clk) begin
			if (valid_s1 && active[k]) begin
				if (first[k]) begin
					value_q[k] <= value_s1;
					mag_q[k]   <= mag_s1;
					occ_q[k]   <= occ_s1;
					vir_q[k]   <= vir_s1;
				end else if (prior_hit[k]) begin
					value_q[k] <= prev_value;
					mag_q[k]   <= prev_mag;
					occ_q[k]   <= prev_occ;
					vir_q[k]   <= prev_vir;
				end
			end else if (cmd.dump_step && active[k]) begin
				value_q[k] <= next_active ? next_value : '0;
				mag_q[k]   <= next_active ? next_mag : '0;
				occ_q[k]   <= next_active ? next_occ : '0;
				vir_q[k]   <= next_active ? next_vir : '0;
			end
		end
	end

	assign out_free        = !out_valid || out_ready;
	assign status.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.dump_step) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dump_step) begin
			rank          <= cmd.rank;
			excitation    <= full_q[0] ? value_q[0] : '0;
			out_occ_index <= full_q[0] ? occ_q[0] : '0;
			out_vir_index <= full_q[0] ? vir_q[0] : '0;
			entry_valid   <= full_q[0];
			last          <= cmd.dump_last;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/smallest_magnitude_top_k_selector_core.sv -----
// Top level of the smallest-magnitude top-k selector: stream ports, controller and datapath.
//
// Usage:
//   s_axis carries one candidate per request: occupied and virtual energies
//   (signed Q16.16) and their indices; tlast marks the final candidate.
//   Each candidate's excitation (virtual minus occupied) is sorted into a
//   list of the roots_in_use smallest magnitudes; ties keep arrival order.
//   cfg_valid/cfg_data write roots_in_use (clamped to 1..MAX_ROOTS); write
//   it only while the block is idle.
//   Throughput is one candidate per cycle while s_axis_tready is high: every
//   slot compares and shifts in parallel in the cycle after the candidate is taken.
//   After the final candidate, s_axis_tready drops for the flush state and
//   then for the dump: one result per cycle on m_axis unless stalled, roots_in_use
//   results in rank order, each marked in tuser as a full or an empty slot, tlast on
//   the final one. The first result is registered after the flush state and the
//   first dump step. The dump pops the list from the head and leaves it cleared.
//   A stalled m_axis holds the result register and pauses the dump; intake
//   resumes as soon as the final result sits in the output register.
//   arst_n clears the list, sets roots_in_use to 16 and drops all valids.
`timescale 1ns / 1ps
`default_nettype none
module smallest_magnitude_top_k_selector_core #(
	parameter int MAX_ROOTS = 16,
	parameter int OCC_BITS  = 8,
	parameter int VIR_BITS  = 10,
	localparam int IN_W  = ((2 * smtks_pkg::ENERGY_W + OCC_BITS + VIR_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((smtks_pkg::RANK_W + smtks_pkg::VALUE_W + OCC_BITS + VIR_BITS + 7)
	                       / 8) * 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [smtks_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// occ_energy, vir_energy, occ_index, vir_index, zero pad
	input  wire logic [IN_W-1:0]             s_axis_tdata,
	input  wire logic                        s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// rank, excitation, out_occ_index, out_vir_index, zero pad
	output logic [OUT_W-1:0]                 m_axis_tdata,
	// entry_valid
	output logic                             m_axis_tuser,
	output logic                             m_axis_tlast
);
	import smtks_pkg::*;

	localparam int CNT_W = $clog2(MAX_ROOTS + 1);

	smtks_cmd_t    cmd;
	smtks_status_t status;
	logic [CNT_W-1:0]    eff_cnt;
	logic [RANK_W-1:0]   rank;
	logic [VALUE_W-1:0]  excitation;
	logic [OCC_BITS-1:0] out_occ_index;
	logic [VIR_BITS-1:0] out_vir_index;

	assign cfg_ready = 1'b1;

	smtks_ctrl #(
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.eff_cnt  (eff_cnt),
		.status   (status),
		.cmd      (cmd)
	);

	smtks_datapath #(
		.MAX_ROOTS (MAX_ROOTS),
		.OCC_BITS  (OCC_BITS),
		.VIR_BITS  (VIR_BITS),
		.CNT_W     (CNT_W)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.occ_energy    (s_axis_tdata[ENERGY_W-1:0]),
		.vir_energy    (s_axis_tdata[2*ENERGY_W-1:ENERGY_W]),
		.occ_index     (s_axis_tdata[2*ENERGY_W+OCC_BITS-1:2*ENERGY_W]),
		.vir_index     (s_axis_tdata[2*ENERGY_W+OCC_BITS+VIR_BITS-1:2*ENERGY_W+OCC_BITS]),
		.cmd           (cmd),
		.status        (status),
		.eff_cnt       (eff_cnt),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.rank          (rank),
		.excitation    (excitation),
		.out_occ_index (out_occ_index),
		.out_vir_index (out_vir_index),
		.entry_valid   (m_axis_tuser),
		.last          (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_W'({out_vir_index, out_occ_index, excitation, rank});

endmodule
`default_nettype wire
